/* rtl/mbss_pkg.sv */
// shared constants and types of the masked byte signature scanner
`timescale 1ns / 1ps

package mbss_pkg;

	localparam int MAX_SIG     = 16;
	localparam int WIN_IDX_W   = $clog2(MAX_SIG);
	localparam int LEN_W       = $clog2(MAX_SIG + 1);
	localparam int OFFSET_BITS = 32;
	localparam int OFS_OUT_W   = 32;
	localparam int ADDR_W      = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CARE     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = CFG_IDX_W'(4);

	localparam logic [MAX_SIG-1:0] CARE_RESET   = '1;
	localparam logic [LEN_W-1:0]   LENGTH_RESET = LEN_W'(MAX_SIG);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [MAX_SIG-1:0][7:0] sig;
		logic [MAX_SIG-1:0]      care;
		logic [LEN_W-1:0]        len;   // already clamped to 1..MAX_SIG
		logic [ADDR_W-1:0]       base;
	} cfg_t;

	typedef struct packed {
		logic                 found;
		logic [OFS_OUT_W-1:0] match_offset;
		logic [ADDR_W-1:0]    match_address;
	} res_t;

endpackage

/* rtl/mbss_ifs.sv */
// channel interfaces: byte input, result output, configuration writes
`timescale 1ns / 1ps

interface mbss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       region_end;

	modport source (output valid, output data_byte, output region_end, input ready);
	modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

interface mbss_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_offset;
	logic [63:0] match_address;

	modport source (output valid, output found, output match_offset, output match_address,
		input ready);
	modport sink (input valid, input found, input match_offset, input match_address,
		output ready);
endinterface

interface mbss_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mbss_pkg::CFG_IDX_W-1:0]  index;
	logic [mbss_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/masked_byte_signature_scanner.sv */
// top level of the masked byte signature scanner
`timescale 1ns / 1ps

// Scans a byte stream for a signature of up to 16 bytes, each byte either
// compared or a wildcard (care_mask bit clear). One byte is taken per beat on
// scan_in; region_end marks the last byte of a region. The first window in a
// region whose cared-for bytes all match gives one found beat with the start
// offset and base_address plus that offset, and the rest of the region is
// then dropped silently. A region that ends without a match, including one
// shorter than the signature, gives a not-found beat with zero offset and
// address. The region byte count saturates at its top value. Throughput is
// one byte per clock while the result register has room; an accepted byte
// sits in the input register, then the window shift, the 16 parallel
// byte compares and the offset add feed the result register. Configuration
// writes are taken at any time on cfg but are meant for when the scanner is
// idle. No clearing pass follows reset.
module masked_byte_signature_scanner (
	input  logic       clk,
	input  logic       arst_n,
	mbss_cfg_if.sink   cfg,
	mbss_in_if.sink    scan_in,
	mbss_out_if.source result_out
);
	import mbss_pkg::*;

	cfg_t cfg_val;     // clamped register values
	res_t res;         // result of the current byte
	logic res_valid;   // that byte produces a result beat
	logic out_free;    // result register can take a new result

	mbss_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	// window, count and compare; advances only when the result register has room
	mbss_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_in   (scan_in),
		.cfg_val   (cfg_val),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	mbss_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (res_valid),
		.res        (res),
		.out_free   (out_free),
		.result_out (result_out)
	);

endmodule

/* rtl/mbss_cfg_regs.sv */
// configuration register file with signature length clamping
`timescale 1ns / 1ps

module mbss_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	mbss_cfg_if.sink       cfg,
	output mbss_pkg::cfg_t cfg_val
);
	import mbss_pkg::*;

	logic [63:0]        sig_low_q;
	logic [63:0]        sig_high_q;
	logic [MAX_SIG-1:0] care_q;
	logic [LEN_W-1:0]   len_q;
	logic [ADDR_W-1:0]  base_q;
	logic               wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_low_q  <= '0;
			sig_high_q <= '0;
			care_q     <= CARE_RESET;
			len_q      <= LENGTH_RESET;
			base_q     <= '0;
		end else if (wr) begin
			case (cfg.index)
				REG_SIG_LOW:  sig_low_q  <= cfg.data[63:0];
				REG_SIG_HIGH: sig_high_q <= cfg.data[63:0];
				REG_CARE:     care_q     <= cfg.data[MAX_SIG-1:0];
				REG_LENGTH:   len_q      <= cfg.data[LEN_W-1:0];
				REG_BASE:     base_q     <= cfg.data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the window size as the window size
	always_comb begin
		cfg_val.sig  = {sig_high_q, sig_low_q};
		cfg_val.care = care_q;
		cfg_val.base = base_q;
		if (len_q == '0)
			cfg_val.len = LEN_W'(1);
		else if (len_q > LEN_W'(MAX_SIG))
			cfg_val.len = LEN_W'(MAX_SIG);
		else
			cfg_val.len = len_q;
	end

endmodule

/* rtl/mbss_scan.sv */
// input register, byte window, region counter and masked compare
`timescale 1ns / 1ps

module mbss_scan (
	input  logic           clk,
	input  logic           arst_n,
	mbss_in_if.sink        scan_in,
	input  mbss_pkg::cfg_t cfg_val,
	input  logic           out_free,
	output logic           res_valid,
	output mbss_pkg::res_t res
);
	import mbss_pkg::*;

	logic                   valid_s1;
	byte_t                  data_s1;
	logic                   last_s1;

	byte_t                  win_q [MAX_SIG];
	byte_t                  win_n [MAX_SIG];
	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_n;
	logic [OFFSET_BITS-1:0] len_ext;
	logic [OFFSET_BITS-1:0] off;
	logic                   rep_q;
	logic                   step;
	logic                   enough;
	logic                   hit;
	logic [MAX_SIG-1:0]     miss;

	assign step          = valid_s1 && out_free;
	assign scan_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_in.ready) begin
			valid_s1 <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.ready && scan_in.valid) begin
			data_s1 <= scan_in.data_byte;
			last_s1 <= scan_in.region_end;
		end
	end

	always_comb begin
		win_n[0] = data_s1;
		for (int i = 1; i < MAX_SIG; i++)
			win_n[i] = win_q[i-1];
	end

	assign count_n = (count_q == '1) ? count_q : count_q + OFFSET_BITS'(1);
	assign len_ext = OFFSET_BITS'(cfg_val.len);
	assign enough  = count_n >= len_ext;
	assign off     = count_n - len_ext;

	// signature byte k lines up with window entry len-1-k
	always_comb begin
		logic [LEN_W-1:0] pos;
		for (int k = 0; k < MAX_SIG; k++) begin
			pos     = cfg_val.len - LEN_W'(k) - LEN_W'(1);
			miss[k] = (LEN_W'(k) < cfg_val.len) && cfg_val.care[k]
				&& (cfg_val.sig[k] != win_n[pos[WIN_IDX_W-1:0]]);
		end
	end

	assign hit       = enough && (miss == '0);
	assign res_valid = step && !rep_q && (hit || last_s1);

	always_comb begin
		res.found         = hit;
		res.match_offset  = hit ? OFS_OUT_W'(off) : '0;
		res.match_address = hit ? cfg_val.base + ADDR_W'(off) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SIG; i++)
				win_q[i] <= '0;
			count_q <= '0;
			rep_q   <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				for (int i = 0; i < MAX_SIG; i++)
					win_q[i] <= '0;
				count_q <= '0;
				rep_q   <= 1'b0;
			end else if (!rep_q) begin
				for (int i = 0; i < MAX_SIG; i++)
					win_q[i] <= win_n[i];
				count_q <= count_n;
				rep_q   <= hit;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> (count_q == '0) && !rep_q)
		else $error("region end did not clear the scan state");

	a_quiet_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> !res_valid)
		else $error("result produced after a match was already reported");

	a_match_latches: assert property (@(posedge clk) disable iff (!arst_n)
		step && !rep_q && hit && !last_s1 |=> rep_q)
		else $error("match inside a region not remembered");

	a_no_step_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> valid_s1 && out_free)
		else $error("result raised without a byte taken from the input register");

endmodule

/* rtl/mbss_out_stage.sv */
// result register toward the output channel
`timescale 1ns / 1ps

module mbss_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mbss_pkg::res_t res,
	output logic           out_free,
	mbss_out_if.source     result_out
);
	import mbss_pkg::*;

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign result_out.valid         = valid_q;
	assign result_out.found         = res_q.found;
	assign result_out.match_offset  = res_q.match_offset;
	assign result_out.match_address = res_q.match_address;

endmodule
